### sv/fees_pkg.sv
`timescale 1ns / 1ps
package fees_pkg;

  localparam int DataW     = 32;
  localparam int SumW      = 54;
  localparam int CountW    = 23;
  localparam int LimitW    = 31;
  localparam int MaxPixels = 4194304;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [CountW-1:0] CountCap =
    (MaxPixels > (2**CountW - 1)) ? CountMax : CountW'(MaxPixels);

  localparam logic [LimitW-1:0] LimitReset = 31'd256000000;
  localparam logic [DataW-1:0]  ErrMax     = {DataW{1'b1}};
  localparam logic [SumW-1:0]   SumMax     = {SumW{1'b1}};

  localparam int SqrtSteps  = DataW;
  localparam int DivSteps   = SumW;
  localparam int QueueDepth = 2;
  localparam int QueuePtrW  = $clog2(QueueDepth);

  localparam int  AddrW           = 3;
  localparam logic RegUnknownLimit = 1'b0;

  typedef struct packed {
    logic [DataW-1:0] du;
    logic [DataW-1:0] dv;
    logic             known;
    logic             last;
  } entry_t;

endpackage

### sv/fees_front.sv
`timescale 1ns / 1ps
module fees_front import fees_pkg::*; (
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DataW-1:0]  flow_u_i,
  input  logic signed [DataW-1:0]  flow_v_i,
  input  logic signed [DataW-1:0]  truth_u_i,
  input  logic signed [DataW-1:0]  truth_v_i,
  input  logic                     last_pixel_i,
  input  logic [LimitW-1:0]        limit_i,
  input  logic                     q_full_i,
  output logic                     push_o,
  output entry_t                   entry_o
);

  logic [DataW-1:0] tu_mag;
  logic [DataW-1:0] tv_mag;
  logic [DataW:0]   du_diff;
  logic [DataW:0]   dv_diff;
  logic [DataW:0]   du_abs;
  logic [DataW:0]   dv_abs;

  always_comb begin
    tu_mag  = truth_u_i[DataW-1] ? (~truth_u_i + 1'b1) : truth_u_i;
    tv_mag  = truth_v_i[DataW-1] ? (~truth_v_i + 1'b1) : truth_v_i;
    du_diff = {flow_u_i[DataW-1], flow_u_i} - {truth_u_i[DataW-1], truth_u_i};
    dv_diff = {flow_v_i[DataW-1], flow_v_i} - {truth_v_i[DataW-1], truth_v_i};
    du_abs  = du_diff[DataW] ? (~du_diff + 1'b1) : du_diff;
    dv_abs  = dv_diff[DataW] ? (~dv_diff + 1'b1) : dv_diff;
  end

  assign in_ready_o    = !q_full_i;
  assign push_o        = in_valid_i && !q_full_i;
  assign entry_o.du    = du_abs[DataW-1:0];
  assign entry_o.dv    = dv_abs[DataW-1:0];
  assign entry_o.known = (tu_mag <= {1'b0, limit_i}) && (tv_mag <= {1'b0, limit_i});
  assign entry_o.last  = last_pixel_i;

endmodule

### sv/fees_queue.sv
`timescale 1ns / 1ps
module fees_queue import fees_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  output logic   valid_o,
  input  logic   pop_i,
  output entry_t entry_o
);

  entry_t                slot_q [QueueDepth];
  logic [QueuePtrW-1:0]  wptr_q;
  logic [QueuePtrW-1:0]  rptr_q;
  logic [QueuePtrW:0]    cnt_q;

  assign full_o  = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign entry_o = slot_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

endmodule

### sv/fees_back.sv
`timescale 1ns / 1ps
module fees_back import fees_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  entry_t            q_entry_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DataW-1:0]  pixel_error_o,
  output logic              pixel_valid_o,
  output logic              frame_done_o,
  output logic [DataW-1:0]  max_error_o,
  output logic [DataW-1:0]  mean_error_o,
  output logic [SumW-1:0]   error_sum_o,
  output logic [CountW-1:0] valid_count_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_ADD,
    ST_SQRT,
    ST_UPD,
    ST_DIV,
    ST_FIN
  } state_e;

  state_e                state_q;
  entry_t                cur_q;
  logic [2*DataW-1:0]    a_q;
  logic [2*DataW-1:0]    b_q;
  logic [2*DataW-1:0]    n_q;
  logic [DataW+1:0]      rem_q;
  logic [DataW-1:0]      root_q;
  logic [5:0]            iter_q;
  logic [DataW-1:0]      err_q;
  logic [DataW-1:0]      max_q;
  logic [SumW-1:0]       sum_q;
  logic [CountW-1:0]     count_q;
  logic [SumW-1:0]       dq_q;
  logic [CountW-1:0]     drem_q;

  logic                  out_valid_q;
  logic [DataW-1:0]      pixel_error_q;
  logic                  pixel_valid_q;
  logic                  frame_done_q;
  logic [DataW-1:0]      max_error_q;
  logic [DataW-1:0]      mean_error_q;
  logic [SumW-1:0]       error_sum_q;
  logic [CountW-1:0]     valid_count_q;

  logic [DataW-1:0]      mul_op;
  logic [2*DataW-1:0]    prod;
  logic [2*DataW:0]      sum_ab;
  logic [DataW+3:0]      rem_sh;
  logic [DataW+3:0]      trial;
  logic                  sq_ge;
  logic [DataW+3:0]      sq_diff;
  logic [DataW-1:0]      root_nx;
  logic [SumW:0]         sum_add;
  logic                  do_count;
  logic [CountW-1:0]     count_upd;
  logic [SumW-1:0]       sum_upd;
  logic [DataW-1:0]      max_upd;
  logic [CountW:0]       drem_sh;
  logic                  div_ge;
  logic [CountW:0]       div_diff;
  logic                  out_free;

  always_comb begin
    mul_op    = (state_q == ST_MULA) ? cur_q.du : cur_q.dv;
    prod      = (2*DataW)'(mul_op) * (2*DataW)'(mul_op);
    sum_ab    = {1'b0, a_q} + {1'b0, b_q};
    rem_sh    = {rem_q, n_q[2*DataW-1 -: 2]};
    trial     = {2'b00, root_q, 2'b01};
    sq_ge     = (rem_sh >= trial);
    sq_diff   = rem_sh - trial;
    root_nx   = {root_q[DataW-2:0], sq_ge};
    sum_add   = {1'b0, sum_q} + (SumW+1)'(err_q);
    do_count  = cur_q.known && (count_q < CountCap);
    count_upd = do_count ? (count_q + 1'b1) : count_q;
    sum_upd   = !do_count ? sum_q : (sum_add[SumW] ? SumMax : sum_add[SumW-1:0]);
    max_upd   = (cur_q.known && (err_q > max_q)) ? err_q : max_q;
    drem_sh   = {drem_q, dq_q[SumW-1]};
    div_ge    = (drem_sh >= {1'b0, count_q});
    div_diff  = drem_sh - {1'b0, count_q};
    out_free  = !out_valid_q || out_ready_i;
  end

  assign q_pop_o = (state_q == ST_IDLE) && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cur_q         <= '0;
      a_q           <= '0;
      b_q           <= '0;
      n_q           <= '0;
      rem_q         <= '0;
      root_q        <= '0;
      iter_q        <= '0;
      err_q         <= '0;
      max_q         <= '0;
      sum_q         <= '0;
      count_q       <= '0;
      dq_q          <= '0;
      drem_q        <= '0;
      out_valid_q   <= 1'b0;
      pixel_error_q <= '0;
      pixel_valid_q <= 1'b0;
      frame_done_q  <= 1'b0;
      max_error_q   <= '0;
      mean_error_q  <= '0;
      error_sum_q   <= '0;
      valid_count_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            cur_q   <= q_entry_i;
            err_q   <= '0;
            state_q <= q_entry_i.known ? ST_MULA : ST_UPD;
          end
        end
        ST_MULA: begin
          a_q     <= prod;
          state_q <= ST_MULB;
        end
        ST_MULB: begin
          b_q     <= prod;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (sum_ab[2*DataW]) begin
            err_q   <= ErrMax;
            state_q <= ST_UPD;
          end else begin
            n_q     <= sum_ab[2*DataW-1:0];
            rem_q   <= '0;
            root_q  <= '0;
            iter_q  <= '0;
            state_q <= ST_SQRT;
          end
        end
        ST_SQRT: begin
          n_q    <= {n_q[2*DataW-3:0], 2'b00};
          rem_q  <= sq_ge ? sq_diff[DataW+1:0] : rem_sh[DataW+1:0];
          root_q <= root_nx;
          if (iter_q == 6'(SqrtSteps - 1)) begin
            err_q   <= root_nx;
            state_q <= ST_UPD;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_UPD: begin
          max_q   <= max_upd;
          count_q <= count_upd;
          sum_q   <= sum_upd;
          if (cur_q.last && (count_upd != '0)) begin
            dq_q    <= sum_upd;
            drem_q  <= '0;
            iter_q  <= '0;
            state_q <= ST_DIV;
          end else begin
            dq_q    <= '0;
            state_q <= ST_FIN;
          end
        end
        ST_DIV: begin
          dq_q   <= {dq_q[SumW-2:0], div_ge};
          drem_q <= div_ge ? div_diff[CountW-1:0] : drem_sh[CountW-1:0];
          if (iter_q == 6'(DivSteps - 1)) begin
            state_q <= ST_FIN;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_valid_q   <= 1'b1;
            pixel_error_q <= err_q;
            pixel_valid_q <= cur_q.known;
            frame_done_q  <= cur_q.last;
            if (cur_q.last) begin
              max_error_q   <= max_q;
              mean_error_q  <= (dq_q > SumW'(ErrMax)) ? ErrMax : dq_q[DataW-1:0];
              error_sum_q   <= sum_q;
              valid_count_q <= count_q;
              max_q         <= '0;
              sum_q         <= '0;
              count_q       <= '0;
            end else begin
              max_error_q   <= '0;
              mean_error_q  <= '0;
              error_sum_q   <= '0;
              valid_count_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_error_o = pixel_error_q;
  assign pixel_valid_o = pixel_valid_q;
  assign frame_done_o  = frame_done_q;
  assign max_error_o   = max_error_q;
  assign mean_error_o  = mean_error_q;
  assign error_sum_o   = error_sum_q;
  assign valid_count_o = valid_count_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountCap)
    else $error("valid count above cap");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DIV |-> count_q != '0)
    else $error("division by zero count");

  a_frame_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free && cur_q.last) |=>
      (count_q == '0 && sum_q == '0 && max_q == '0))
    else $error("accumulators not cleared after frame");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |-> pixel_error_o == '0)
    else $error("unknown pixel carries an error");

  a_frame_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !frame_done_o) |->
      (max_error_o == '0 && mean_error_o == '0 && error_sum_o == '0 &&
       valid_count_o == '0))
    else $error("frame fields set outside frame end");
`endif

endmodule

### sv/flow_endpoint_error_stats_core.sv
`timescale 1ns / 1ps
// Endpoint error statistics for one optical-flow frame.
// Input channel (in_valid_i/in_ready_o): one pixel per transaction, computed
// and ground-truth flow in signed Q24.8 plus a last_pixel mark.
// Output channel (out_valid_o/out_ready_i): one result per pixel, the pixel's
// endpoint error and, on the last pixel, max, sum, count and mean of the frame.
// APB port: register 0 at address 0 holds the unknown limit (31 bits).
// A front stage classifies each pixel and writes a two-entry queue; the back
// sequencer squares the differences on one shared 32x32 multiplier and takes
// the square root one result bit per cycle.
// The back sequencer takes a new pixel only after finishing the previous one:
// a known pixel is squared, summed and run through the 32-step square root
// loop, one whose squared error overflows skips the root, an unknown one goes
// straight to the accumulator update, and the last pixel of a frame with
// counted pixels then runs the bit-serial mean division.
// Reset clears the accumulators and loads the limit with 256000000 (1e6).
// When the receiver stalls, the finished result holds in the output register,
// the back sequencer waits, and the queue takes up to two more pixels before
// in_ready_o drops.
module flow_endpoint_error_stats_core import fees_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [AddrW-1:0]         paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [DataW-1:0]  flow_u_i,
  input  logic signed [DataW-1:0]  flow_v_i,
  input  logic signed [DataW-1:0]  truth_u_i,
  input  logic signed [DataW-1:0]  truth_v_i,
  input  logic                     last_pixel_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [DataW-1:0]         pixel_error_o,
  output logic                     pixel_valid_o,
  output logic                     frame_done_o,
  output logic [DataW-1:0]         max_error_o,
  output logic [DataW-1:0]         mean_error_o,
  output logic [SumW-1:0]          error_sum_o,
  output logic [CountW-1:0]        valid_count_o
);

  logic [LimitW-1:0] limit_q;
  logic              reg_sel;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  entry_t            push_entry;
  entry_t            pop_entry;

  assign reg_sel = (paddr[AddrW-1] == RegUnknownLimit);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {1'b0, limit_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      limit_q <= pwdata[LimitW-1:0];
    end
  end

  fees_front u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .flow_u_i     (flow_u_i),
    .flow_v_i     (flow_v_i),
    .truth_u_i    (truth_u_i),
    .truth_v_i    (truth_v_i),
    .last_pixel_i (last_pixel_i),
    .limit_i      (limit_q),
    .q_full_i     (q_full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  fees_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .entry_o (pop_entry)
  );

  fees_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_entry_i     (pop_entry),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_error_o (pixel_error_o),
    .pixel_valid_o (pixel_valid_o),
    .frame_done_o  (frame_done_o),
    .max_error_o   (max_error_o),
    .mean_error_o  (mean_error_o),
    .error_sum_o   (error_sum_o),
    .valid_count_o (valid_count_o)
  );

endmodule
